// ===== rtl/lcs_pkg.sv =====
// Shared codes and control types for the LCS edit script engine.
`timescale 1ns / 1ps
package lcs_pkg;

  localparam logic [2:0] FUNC_CLEAR   = 3'd0;
  localparam logic [2:0] FUNC_LOAD_A  = 3'd1;
  localparam logic [2:0] FUNC_LOAD_B  = 3'd2;
  localparam logic [2:0] FUNC_COMPUTE = 3'd3;
  localparam logic [2:0] FUNC_FETCH   = 3'd4;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_EDIT    = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  // Edit codes double as the per-cell backtrack direction codes.
  localparam logic [1:0] EDIT_COMMON = 2'd0;
  localparam logic [1:0] EDIT_INS    = 2'd1;
  localparam logic [1:0] EDIT_DEL    = 2'd2;

  localparam int EDIT_W = 2;

  typedef struct packed {
    logic init;
    logic load_b;
  } cell_ctl_t;

endpackage

// ===== rtl/lcs_ram.sv =====
// Generic single write port, registered read RAM.
`timescale 1ns / 1ps
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lcs_cell.sv =====
// One column cell of the systolic LCS array: holds a B token and its column scores.
`timescale 1ns / 1ps
module lcs_cell #(
  parameter int TOKEN_BITS = 32,
  parameter int SC_W       = 7,
  parameter int IDX_W      = 6,
  parameter int ROWS       = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lcs_pkg::cell_ctl_t     ctl,
  input  logic [TOKEN_BITS-1:0]  b_token,
  input  logic [TOKEN_BITS-1:0]  a_in,
  input  logic                   a_valid_in,
  input  logic [IDX_W-1:0]       row_in,
  input  logic [SC_W-1:0]        left_in,
  output logic [TOKEN_BITS-1:0]  a_out,
  output logic                   a_valid_out,
  output logic [IDX_W-1:0]       row_out,
  output logic [SC_W-1:0]        score_out,
  input  logic [IDX_W-1:0]       rd_addr,
  output logic [1:0]             dir_out
);

  logic [TOKEN_BITS-1:0] b_tok;
  logic [SC_W-1:0]       score;
  logic [SC_W-1:0]       diag;
  logic [SC_W-1:0]       score_next;
  logic [1:0]            dir_code;
  logic                  eq;

  always_comb begin
    eq = (a_in == b_tok);
    if (eq) begin
      score_next = diag + 1'b1;
      dir_code   = lcs_pkg::EDIT_COMMON;
    end else if (left_in >= score) begin
      score_next = left_in;
      dir_code   = lcs_pkg::EDIT_INS;
    end else begin
      score_next = score;
      dir_code   = lcs_pkg::EDIT_DEL;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      b_tok <= b_token;
    end
    if (rst) begin
      a_valid_out <= 1'b0;
    end else begin
      a_valid_out <= a_valid_in;
    end
    a_out   <= a_in;
    row_out <= row_in;
    // Row zero border: all scores start at zero.
    if (ctl.init) begin
      score <= '0;
      diag  <= '0;
    end else if (a_valid_in) begin
      score <= score_next;
      diag  <= left_in;
    end
  end

  assign score_out = score;

  lcs_ram #(
    .WIDTH (2),
    .DEPTH (ROWS)
  ) u_dir (
    .clk   (clk),
    .we    (a_valid_in),
    .waddr (row_in),
    .wdata (dir_code),
    .raddr (rd_addr),
    .rdata (dir_out)
  );

endmodule

// ===== rtl/lcs_edit_script.sv =====
// Top level of the LCS edit script engine: controller, sequence A store, cell chain, edit store.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  command  | start, busy, func, token                         | in; busy out
//  result   | done, kind, common_lines, edit_count, truncated, | out
//           | edit_kind, a_line, b_line, has_a, has_b, last    |
//
// A fetch result shows on done in the cycle after the fetch is accepted.
// Compute sweeps A through the cell chain (skipped when A is empty), then backtracks one edit
// at a time, reading a direction only where neither side is empty, and then shows the
// summary on done; busy is high throughout.
// Each cell keeps one direction RAM; backtrack reads all of them at one row and muxes a column.
// Reset is synchronous and leaves empty sequences and an empty script; no clearing pass.
// The result receiver cannot stall; done pulses for exactly one cycle per result.
`timescale 1ns / 1ps
module lcs_edit_script #(
  parameter int MAX_ITEMS  = 64,
  parameter int TOKEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] token,
  output logic        done,
  output logic [1:0]  kind,
  output logic [6:0]  common_lines,
  output logic [7:0]  edit_count,
  output logic        truncated,
  output logic [1:0]  edit_kind,
  output logic [5:0]  a_line,
  output logic [5:0]  b_line,
  output logic        has_a,
  output logic        has_b,
  output logic        last
);

  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int LEN_W  = $clog2(MAX_ITEMS + 1);
  localparam int SC_W   = LEN_W;
  localparam int CNT_W  = $clog2(2 * MAX_ITEMS + 1);
  localparam int EDEPTH = 2 * MAX_ITEMS;
  localparam int EIDX_W = $clog2(EDEPTH);
  localparam int ENT_W  = lcs_pkg::EDIT_W + 2 * IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_BT_ISSUE,
    ST_BT_DEC
  } state_t;

  state_t state;

  logic [LEN_W-1:0]      a_len;
  logic [LEN_W-1:0]      b_len;
  logic                  overflow;
  logic [CNT_W-1:0]      edit_total;
  logic [CNT_W-1:0]      fetch_ptr;
  logic [SC_W-1:0]       lcs_found;
  logic [LEN_W-1:0]      fill_k;
  logic [CNT_W-1:0]      drain_cnt;
  logic                  feed_valid;
  logic [IDX_W-1:0]      feed_row;
  logic [LEN_W-1:0]      bt_i;
  logic [LEN_W-1:0]      bt_j;
  logic [CNT_W-1:0]      bt_cnt;
  logic [SC_W-1:0]       bt_lcs;
  logic [1:0]            out_kind;

  logic                  accept;
  logic [TOKEN_BITS-1:0] tok;
  logic                  a_we;
  logic [TOKEN_BITS-1:0] a_q;
  logic                  init;
  logic [LEN_W-1:0]      im1;
  logic [LEN_W-1:0]      jm1;
  logic                  e_we;
  logic [1:0]            e_op;
  logic [ENT_W-1:0]      e_wdata;
  logic [EIDX_W-1:0]     e_raddr;
  logic [ENT_W-1:0]      e_rdata;
  logic [1:0]            q_op;
  logic [IDX_W-1:0]      q_ai;
  logic [IDX_W-1:0]      q_bi;
  logic                  out_edit;

  logic [TOKEN_BITS-1:0] chain_a     [MAX_ITEMS+1];
  logic                  chain_v     [MAX_ITEMS+1];
  logic [IDX_W-1:0]      chain_row   [MAX_ITEMS+1];
  logic [SC_W-1:0]       chain_score [MAX_ITEMS+1];
  logic [1:0]            dir_q       [MAX_ITEMS];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign tok    = TOKEN_BITS'(token);
  assign a_we   = accept && (func == lcs_pkg::FUNC_LOAD_A) && (a_len < LEN_W'(MAX_ITEMS));
  assign init   = accept && (func == lcs_pkg::FUNC_COMPUTE);
  assign im1    = bt_i - 1'b1;
  assign jm1    = bt_j - 1'b1;

  lcs_ram #(
    .WIDTH (TOKEN_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_seq_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_len[IDX_W-1:0]),
    .wdata (tok),
    .raddr (fill_k[IDX_W-1:0]),
    .rdata (a_q)
  );

  assign chain_a[0]     = a_q;
  assign chain_v[0]     = feed_valid;
  assign chain_row[0]   = feed_row;
  assign chain_score[0] = '0;

  for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
    lcs_pkg::cell_ctl_t ctl;
    always_comb begin
      ctl.init   = init;
      ctl.load_b = accept && (func == lcs_pkg::FUNC_LOAD_B)
                   && (b_len == LEN_W'(c));
    end
    lcs_cell #(
      .TOKEN_BITS (TOKEN_BITS),
      .SC_W       (SC_W),
      .IDX_W      (IDX_W),
      .ROWS       (MAX_ITEMS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .b_token     (tok),
      .a_in        (chain_a[c]),
      .a_valid_in  (chain_v[c]),
      .row_in      (chain_row[c]),
      .left_in     (chain_score[c]),
      .a_out       (chain_a[c+1]),
      .a_valid_out (chain_v[c+1]),
      .row_out     (chain_row[c+1]),
      .score_out   (chain_score[c+1]),
      .rd_addr     (im1[IDX_W-1:0]),
      .dir_out     (dir_q[c])
    );
  end

  // Backtrack step: edge of the table first, else the direction read from the column.
  always_comb begin
    e_we = 1'b0;
    e_op = lcs_pkg::EDIT_INS;
    unique case (state)
      ST_BT_ISSUE: begin
        if (bt_i == '0 && bt_j != '0) begin
          e_we = 1'b1;
          e_op = lcs_pkg::EDIT_INS;
        end else if (bt_i != '0 && bt_j == '0) begin
          e_we = 1'b1;
          e_op = lcs_pkg::EDIT_DEL;
        end
      end
      ST_BT_DEC: begin
        e_we = 1'b1;
        e_op = dir_q[jm1[IDX_W-1:0]];
      end
      default: begin
        e_we = 1'b0;
      end
    endcase
  end

  assign e_wdata = {e_op, im1[IDX_W-1:0], jm1[IDX_W-1:0]};
  // Edits are stored newest first; read back from the top for forward order.
  assign e_raddr = EIDX_W'(edit_total - fetch_ptr - 1'b1);

  lcs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (EDEPTH)
  ) u_edits (
    .clk   (clk),
    .we    (e_we),
    .waddr (bt_cnt[EIDX_W-1:0]),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      a_len      <= '0;
      b_len      <= '0;
      overflow   <= 1'b0;
      edit_total <= '0;
      fetch_ptr  <= '0;
      lcs_found  <= '0;
      feed_valid <= 1'b0;
      done       <= 1'b0;
      out_kind   <= lcs_pkg::KIND_SUMMARY;
      last       <= 1'b0;
    end else begin
      done       <= 1'b0;
      last       <= 1'b0;
      feed_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (func)
              lcs_pkg::FUNC_CLEAR: begin
                a_len      <= '0;
                b_len      <= '0;
                overflow   <= 1'b0;
                edit_total <= '0;
                fetch_ptr  <= '0;
                lcs_found  <= '0;
              end
              lcs_pkg::FUNC_LOAD_A: begin
                if (a_len < LEN_W'(MAX_ITEMS)) a_len <= a_len + 1'b1;
                else overflow <= 1'b1;
              end
              lcs_pkg::FUNC_LOAD_B: begin
                if (b_len < LEN_W'(MAX_ITEMS)) b_len <= b_len + 1'b1;
                else overflow <= 1'b1;
              end
              lcs_pkg::FUNC_COMPUTE: begin
                fill_k <= '0;
                bt_i   <= a_len;
                bt_j   <= b_len;
                bt_cnt <= '0;
                bt_lcs <= '0;
                state  <= (a_len == '0) ? ST_BT_ISSUE : ST_FILL;
              end
              lcs_pkg::FUNC_FETCH: begin
                done <= 1'b1;
                if (fetch_ptr < edit_total) begin
                  out_kind  <= lcs_pkg::KIND_EDIT;
                  last      <= (fetch_ptr + 1'b1 == edit_total);
                  fetch_ptr <= fetch_ptr + 1'b1;
                end else begin
                  out_kind <= lcs_pkg::KIND_NONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL: begin
          feed_valid <= 1'b1;
          feed_row   <= fill_k[IDX_W-1:0];
          fill_k     <= fill_k + 1'b1;
          if (fill_k == a_len - 1'b1) begin
            drain_cnt <= CNT_W'(MAX_ITEMS + 1);
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt - 1'b1;
          if (drain_cnt == '0) state <= ST_BT_ISSUE;
        end
        ST_BT_ISSUE: begin
          if (bt_i == '0 && bt_j == '0) begin
            edit_total <= bt_cnt;
            lcs_found  <= bt_lcs;
            fetch_ptr  <= '0;
            done       <= 1'b1;
            out_kind   <= lcs_pkg::KIND_SUMMARY;
            state      <= ST_IDLE;
          end else if (bt_i != '0 && bt_j != '0) begin
            state <= ST_BT_DEC;
          end
        end
        ST_BT_DEC: begin
          state <= ST_BT_ISSUE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (e_we) begin
        bt_cnt <= bt_cnt + 1'b1;
        if (e_op == lcs_pkg::EDIT_COMMON) bt_lcs <= bt_lcs + 1'b1;
        if (e_op != lcs_pkg::EDIT_INS) bt_i <= im1;
        if (e_op != lcs_pkg::EDIT_DEL) bt_j <= jm1;
      end
    end
  end

  assign q_op     = e_rdata[ENT_W-1 -: lcs_pkg::EDIT_W];
  assign q_ai     = e_rdata[2*IDX_W-1 -: IDX_W];
  assign q_bi     = e_rdata[IDX_W-1:0];
  assign out_edit = (out_kind == lcs_pkg::KIND_EDIT);

  assign kind         = out_kind;
  assign common_lines = 7'(lcs_found);
  assign edit_count   = 8'(edit_total);
  assign truncated    = overflow;
  assign edit_kind    = out_edit ? q_op : lcs_pkg::EDIT_COMMON;
  assign has_a        = out_edit && (q_op != lcs_pkg::EDIT_INS);
  assign has_b        = out_edit && (q_op != lcs_pkg::EDIT_DEL);
  assign a_line       = has_a ? 6'(q_ai) : 6'd0;
  assign b_line       = has_b ? 6'(q_bi) : 6'd0;

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && func == lcs_pkg::FUNC_COMPUTE) |=> busy)
    else $error("compute did not raise busy");

  a_edit_has_line: assert property (@(posedge clk) disable iff (rst)
    (done && kind == lcs_pkg::KIND_EDIT) |-> (has_a || has_b))
    else $error("edit entry without a line");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    fetch_ptr <= edit_total)
    else $error("fetch pointer beyond script");

  a_last_is_edit: assert property (@(posedge clk) disable iff (rst)
    last |-> (done && kind == lcs_pkg::KIND_EDIT))
    else $error("last flag outside an edit entry");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    edit_total <= CNT_W'(2 * MAX_ITEMS))
    else $error("edit total exceeds capacity");

endmodule
